>>> hdl/ptt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the priority task table.
// Used by ptt_ctrl, ptt_dpath and priority_task_table_top; depends on nothing.
package ptt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W  = 16;
	localparam int PRI_W = 16;
	localparam int POS_W = 5;
	localparam int REM_W = 4;
	localparam int ENT_W = ID_W + PRI_W;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_NEXT   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_REMOVED = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// What the datapath does with a word that comes back from the table
	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_UPD   = 2'd1,
		PH_BEST  = 2'd2,
		PH_SHIFT = 2'd3
	} phase_t;

	typedef struct packed {
		logic    load_in;
		logic    add_wr;
		logic    ptr_zero;
		logic    ptr_best;
		logic    issue;
		phase_t  phase;
		logic    dec_count;
		logic    res_load;
		status_t res_status;
	} ptt_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       ptr_done;
		logic       vld_s1;
		logic       found;
		logic       out_free;
	} ptt_sts_t;

endpackage

>>> hdl/ptt_ctrl.sv
`timescale 1ns / 1ps
// Controller of the priority task table: sequences add, update and remove.
// Depends on ptt_pkg; drives ptt_dpath through ptt_cmd_t.
module ptt_ctrl
	import ptt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ptt_sts_t sts,
	output ptt_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DISP  = 6'b000010,
		S_UPD   = 6'b000100,
		S_BEST  = 6'b001000,
		S_SHIFT = 6'b010000,
		S_RES   = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	status_t res_q, res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_ADD: begin
						if (sts.full) begin
							res_d   = ST_FULL;
							state_d = S_RES;
						end else begin
							cmd.add_wr = 1'b1;
							state_d    = S_IDLE;
						end
					end
					OP_UPDATE: begin
						cmd.ptr_zero = 1'b1;
						state_d      = S_UPD;
					end
					OP_NEXT: begin
						if (sts.empty) begin
							res_d   = ST_EMPTY;
							state_d = S_RES;
						end else begin
							cmd.ptr_zero = 1'b1;
							state_d      = S_BEST;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_UPD: begin
				cmd.phase = PH_UPD;
				cmd.issue = !sts.ptr_done && !sts.found;
				if (sts.found || (sts.ptr_done && !sts.vld_s1)) begin
					state_d = S_IDLE;
				end
			end
			S_BEST: begin
				cmd.phase = PH_BEST;
				cmd.issue = !sts.ptr_done;
				if (sts.ptr_done && !sts.vld_s1) begin
					cmd.ptr_best = 1'b1;
					state_d      = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.phase = PH_SHIFT;
				cmd.issue = !sts.ptr_done;
				if (sts.ptr_done && !sts.vld_s1) begin
					cmd.dec_count = 1'b1;
					res_d         = ST_REMOVED;
					state_d       = S_RES;
				end
			end
			S_RES: begin
				cmd.res_status = res_q;
				cmd.res_load   = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_REMOVED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> hdl/ptt_dpath.sv
`timescale 1ns / 1ps
// Datapath of the priority task table: entry memory, scan pointer, best-entry
// tracker and result register. Depends on ptt_pkg; steered by ptt_ctrl.
module ptt_dpath
	import ptt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ptt_cmd_t          cmd,
	input  logic [1:0]        in_op,
	input  logic [ID_W-1:0]   in_id,
	input  logic [PRI_W-1:0]  in_pri,
	input  logic              out_ready,
	output logic              out_valid,
	output status_t           out_status,
	output logic [ID_W-1:0]   out_id,
	output logic [POS_W-1:0]  out_pos,
	output logic [REM_W-1:0]  out_rem,
	output ptt_sts_t          sts
);

	logic [ENT_W-1:0] mem_q [DEPTH];

	logic [1:0]       op_q;
	logic [ID_W-1:0]  id_q;
	logic [PRI_W-1:0] pri_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENT_W-1:0] rdata_s1;
	logic             found_q;
	logic             have_best_q;
	logic [ID_W-1:0]  best_id_q;
	logic [PRI_W-1:0] best_pri_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [ID_W-1:0]  out_id_q;
	logic [POS_W-1:0] out_pos_q;
	logic [REM_W-1:0] out_rem_q;

	logic [ID_W-1:0]  rd_id;
	logic [PRI_W-1:0] rd_pri;
	logic             upd_hit;
	logic             better;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             full;

	assign rd_id  = rdata_s1[ENT_W-1:PRI_W];
	assign rd_pri = rdata_s1[PRI_W-1:0];
	assign full   = (count_q == CNT_W'(DEPTH));

	assign upd_hit = (cmd.phase == PH_UPD) && vld_s1 && !found_q && (rd_id == id_q);
	assign better  = !have_best_q || (rd_pri > best_pri_q) ||
		((rd_pri == best_pri_q) && (rd_id < best_id_q));

	// One write port: append, priority rewrite, or close the gap one slot down
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = {id_q, pri_q};
		if (cmd.add_wr) begin
			wr_en = 1'b1;
		end else if (upd_hit) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
		end else if ((cmd.phase == PH_SHIFT) && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IDX_W'(1);
			wr_data = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem_q[rd_ptr_q[IDX_W-1:0]];
			idx_s1   <= rd_ptr_q[IDX_W-1:0];
		end
		if (cmd.load_in) begin
			op_q  <= in_op;
			id_q  <= in_id;
			pri_q <= in_pri;
		end
		if ((cmd.phase == PH_BEST) && vld_s1 && better) begin
			best_id_q  <= rd_id;
			best_pri_q <= rd_pri;
			best_idx_q <= idx_s1;
		end
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			if (cmd.res_status == ST_REMOVED) begin
				out_id_q  <= best_id_q;
				out_pos_q <= POS_W'(CNT_W'(best_idx_q) + CNT_W'(1));
				out_rem_q <= REM_W'(count_q);
			end else begin
				out_id_q  <= '0;
				out_pos_q <= '0;
				out_rem_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_ptr_q    <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.add_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CNT_W'(1);
			end
			priority if (cmd.ptr_zero) begin
				rd_ptr_q <= '0;
			end else if (cmd.ptr_best) begin
				rd_ptr_q <= CNT_W'(best_idx_q) + CNT_W'(1);
			end else if (cmd.issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (cmd.load_in) begin
				found_q     <= 1'b0;
				have_best_q <= 1'b0;
			end else begin
				if (upd_hit) begin
					found_q <= 1'b1;
				end
				if ((cmd.phase == PH_BEST) && vld_s1) begin
					have_best_q <= 1'b1;
				end
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op       = op_q;
	assign sts.full     = full;
	assign sts.empty    = (count_q == '0);
	assign sts.ptr_done = (rd_ptr_q >= count_q);
	assign sts.vld_s1   = vld_s1;
	assign sts.found    = found_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_pos    = out_pos_q;
	assign out_rem    = out_rem_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above table depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) <= count_q))
		else $error("table write beyond the filled region");

	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> !full)
		else $error("append issued on a full table");

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_count |-> (count_q != '0))
		else $error("removal from an empty table");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

endmodule

>>> hdl/priority_task_table_top.sv
`timescale 1ns / 1ps
// Priority task table top level. ADD and ignored opcodes return to idle right after dispatch;
// UPDATE scans up to the matched position (to the end with no match). A result word follows a
// dropped ADD, an empty NEXT or a NEXT removal, the last paced by the single memory read
// port that serves the best-entry scan and then the gap-closing shift from the winner onward.
// Throughput: one word at a time; a stalled result word holds the controller. Reset (arst_n
// low, asynchronous) empties the table and idles. Depends on ptt_pkg, ptt_ctrl and ptt_dpath.
module priority_task_table_top
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] task_id, [31:16] priority_req
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] served_id, [20:16] position,
	                              // [24:21] remaining, [31:25] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	ptt_cmd_t         cmd;
	ptt_sts_t         sts;
	logic             ready;
	status_t          out_status;
	logic [ID_W-1:0]  out_id;
	logic [POS_W-1:0] out_pos;
	logic [REM_W-1:0] out_rem;

	// Controller: takes a command word only when idle, then walks the table
	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: holds entries, scans them one per cycle, registers the result
	ptt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser),
		.in_id      (s_tdata[15:0]),
		.in_pri     (s_tdata[31:16]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_id     (out_id),
		.out_pos    (out_pos),
		.out_rem    (out_rem),
		.sts        (sts)
	);

	assign s_tready = ready;

	// Pack the result word; upper bits stay zero
	assign m_tdata = {7'd0, out_rem, out_pos, out_id};
	assign m_tuser = out_status;

endmodule
